[rtl/tld_pkg.sv]
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types and constants of the terminal line discipline: key codes,
// register indexes, read status codes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tld_pkg;

  localparam int KEY_W      = 8;
  localparam int ERASE_W    = 8;
  localparam int RSTAT_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [KEY_W-1:0] KEY_NUL    = 8'h00;
  localparam logic [KEY_W-1:0] KEY_CTRL_D = 8'h04;
  localparam logic [KEY_W-1:0] KEY_CTRL_H = 8'h08;
  localparam logic [KEY_W-1:0] KEY_CTRL_P = 8'h10;
  localparam logic [KEY_W-1:0] KEY_CTRL_U = 8'h15;
  localparam logic [KEY_W-1:0] KEY_DEL    = 8'h7F;
  localparam logic [KEY_W-1:0] KEY_CR     = 8'h0D;
  localparam logic [KEY_W-1:0] KEY_LF     = 8'h0A;

  localparam logic [ERASE_W-1:0] ERASE_MAX = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BUFFERED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_ENABLE  = 2'd2;

  localparam logic [RSTAT_W-1:0] RS_CHAR    = 2'd0;
  localparam logic [RSTAT_W-1:0] RS_EMPTY   = 2'd1;
  localparam logic [RSTAT_W-1:0] RS_EOF     = 2'd2;
  localparam logic [RSTAT_W-1:0] RS_EOF_HLD = 2'd3;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_KILL_RD,
    ST_KILL_CHK,
    ST_READ_CHK,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DUMP,
    OP_ERASE,
    OP_STORE,
    OP_DROP,
    OP_NOTHING,
    OP_RD_ISSUE,
    OP_RD_FINISH,
    OP_KILL_ISSUE,
    OP_KILL_STEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_dump;
    logic is_kill;
    logic is_erase;
    logic can_store;
    logic line_empty;
    logic none_committed;
    logic mem_is_lf;
    logic out_free;
  } status_t;

endpackage

[rtl/tld_in_if.sv]
// ----------------------------------------------------------------------------
// tld_in_if
// Input channel: valid/ready handshake with one request item per beat.
// ----------------------------------------------------------------------------
interface tld_in_if;

  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [tld_pkg::KEY_W-1:0]   key_code;
  logic                        read_has_data;

  modport source(output valid, req_type, key_code, read_has_data, input ready);
  modport sink(input valid, req_type, key_code, read_has_data, output ready);

endinterface

[rtl/tld_out_if.sv]
// ----------------------------------------------------------------------------
// tld_out_if
// Result channel: valid/ready handshake with one result item per beat.
// ----------------------------------------------------------------------------
interface tld_out_if;

  logic                          valid;
  logic                          ready;
  logic                          echo_valid;
  logic [tld_pkg::KEY_W-1:0]     echo_char;
  logic [tld_pkg::ERASE_W-1:0]   erase_count;
  logic                          line_ready;
  logic                          dump_request;
  logic                          key_dropped;
  logic [tld_pkg::RSTAT_W-1:0]   read_status;
  logic [tld_pkg::KEY_W-1:0]     read_char;
  logic                          read_line_end;

  modport source(output valid, echo_valid, echo_char, erase_count, line_ready,
                 dump_request, key_dropped, read_status, read_char,
                 read_line_end, input ready);
  modport sink(input valid, echo_valid, echo_char, erase_count, line_ready,
               dump_request, key_dropped, read_status, read_char,
               read_line_end, output ready);

endinterface

[rtl/terminal_line_discipline.sv]
// ----------------------------------------------------------------------------
// terminal_line_discipline
// Console line editor over a ring store with read, commit and edit indices:
// stores and echoes keys, erases and kills lines, commits lines and hands
// committed characters to the reader.
//
//   channel  direction  beat
//   in_ch    sink       one key stroke or one reader pull
//   out_ch   source     one result per request
//   cfg_*    write      echo_enable, line_buffered, erase_enable
//
// One request is handled at a time. A read of a stored character adds a
// fetch through the single read port of the store, and a kill line walks
// back with one fetch and one compare per step through that same port.
// The next request is taken as soon as the result sits in the output
// register, even while that beat is stalled. Reset clears the indices and
// sets all three configuration enables; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module terminal_line_discipline #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tld_in_if.sink                            in_ch,
  tld_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [tld_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  tld_pkg::cmd_t    cmd;
  tld_pkg::status_t st;

  tld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  tld_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_ch.req_type),
    .in_key_code       (in_ch.key_code),
    .in_read_has_data  (in_ch.read_has_data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_echo_valid    (out_ch.echo_valid),
    .out_echo_char     (out_ch.echo_char),
    .out_erase_count   (out_ch.erase_count),
    .out_line_ready    (out_ch.line_ready),
    .out_dump_request  (out_ch.dump_request),
    .out_key_dropped   (out_ch.key_dropped),
    .out_read_status   (out_ch.read_status),
    .out_read_char     (out_ch.read_char),
    .out_read_line_end (out_ch.read_line_end),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

[rtl/tld_ctrl.sv]
// ----------------------------------------------------------------------------
// tld_ctrl
// Controller: sequences one request at a time through decode, the
// kill-line walk or the buffer read, and hands the result to the output.
// ----------------------------------------------------------------------------
module tld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tld_pkg::status_t  st,
  output tld_pkg::cmd_t     cmd
);

  tld_pkg::state_t state_r;
  tld_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tld_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = tld_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      tld_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = tld_pkg::OP_CAPTURE;
          state_nxt = tld_pkg::ST_EXEC;
        end
      end
      tld_pkg::ST_EXEC: begin
        state_nxt = tld_pkg::ST_EMIT;
        if (st.is_read) begin
          if (st.none_committed) begin
            cmd.op = tld_pkg::OP_NOTHING;
          end else begin
            cmd.op    = tld_pkg::OP_RD_ISSUE;
            state_nxt = tld_pkg::ST_READ_CHK;
          end
        end else if (st.is_dump) begin
          cmd.op = tld_pkg::OP_DUMP;
        end else if (st.is_kill) begin
          state_nxt = tld_pkg::ST_KILL_RD;
        end else if (st.is_erase) begin
          cmd.op = tld_pkg::OP_ERASE;
        end else if (st.can_store) begin
          cmd.op = tld_pkg::OP_STORE;
        end else begin
          cmd.op = tld_pkg::OP_DROP;
        end
      end
      // The kill walk fetches the character before the edit index, then
      // steps back over it unless it ends the previous line.
      tld_pkg::ST_KILL_RD: begin
        if (st.line_empty) begin
          state_nxt = tld_pkg::ST_EMIT;
        end else begin
          cmd.op    = tld_pkg::OP_KILL_ISSUE;
          state_nxt = tld_pkg::ST_KILL_CHK;
        end
      end
      tld_pkg::ST_KILL_CHK: begin
        if (st.mem_is_lf) begin
          state_nxt = tld_pkg::ST_EMIT;
        end else begin
          cmd.op    = tld_pkg::OP_KILL_STEP;
          state_nxt = tld_pkg::ST_KILL_RD;
        end
      end
      tld_pkg::ST_READ_CHK: begin
        cmd.op    = tld_pkg::OP_RD_FINISH;
        state_nxt = tld_pkg::ST_EMIT;
      end
      tld_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.op    = tld_pkg::OP_EMIT;
          state_nxt = tld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tld_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tld_pkg::OP_CAPTURE) |-> (state_r == tld_pkg::ST_IDLE && in_valid))
    else $error("capture outside idle");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tld_pkg::OP_EMIT) |-> st.out_free)
    else $error("result emitted while output register is occupied");

  a_kill_check_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tld_pkg::ST_KILL_CHK) |-> $past(cmd.op == tld_pkg::OP_KILL_ISSUE))
    else $error("kill check without a preceding fetch");
`endif

endmodule

[rtl/tld_dp.sv]
// ----------------------------------------------------------------------------
// tld_dp
// Datapath: configuration registers, the line store, the read, commit and
// edit indices, the result under construction and the output register.
// ----------------------------------------------------------------------------
module tld_dp #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tld_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_req_type,
  input  logic [tld_pkg::KEY_W-1:0]         in_key_code,
  input  logic                              in_read_has_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_echo_valid,
  output logic [tld_pkg::KEY_W-1:0]         out_echo_char,
  output logic [tld_pkg::ERASE_W-1:0]       out_erase_count,
  output logic                              out_line_ready,
  output logic                              out_dump_request,
  output logic                              out_key_dropped,
  output logic [tld_pkg::RSTAT_W-1:0]       out_read_status,
  output logic [tld_pkg::KEY_W-1:0]         out_read_char,
  output logic                              out_read_line_end,
  input  tld_pkg::cmd_t                     cmd,
  output tld_pkg::status_t                  st
);

  localparam int SLOT_W = $clog2(BUFFER_DEPTH);
  localparam int IDX_W  = SLOT_W + 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUFFER_DEPTH - 1);
  localparam logic [tld_pkg::ERASE_W-1:0] ERASE_W_ONE = tld_pkg::ERASE_W'(1);

  // An index is a slot number plus a wrap bit, so a full store and an
  // empty one are told apart for any depth.
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a[SLOT_W-1:0] == SLOT_LAST) begin
      r = {~a[SLOT_W], {SLOT_W{1'b0}}};
    end else begin
      r = {a[SLOT_W], a[SLOT_W-1:0] + SLOT_W'(1)};
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a[SLOT_W-1:0] == '0) begin
      r = {~a[SLOT_W], SLOT_LAST};
    end else begin
      r = {a[SLOT_W], a[SLOT_W-1:0] - SLOT_W'(1)};
    end
    return r;
  endfunction

  function automatic logic is_full(input logic [IDX_W-1:0] ed,
                                   input logic [IDX_W-1:0] rd);
    return (ed[SLOT_W-1:0] == rd[SLOT_W-1:0]) && (ed[SLOT_W] != rd[SLOT_W]);
  endfunction

  logic echo_en_r, line_buf_r, erase_en_r;

  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] cm_idx_r, cm_idx_nxt;
  logic [IDX_W-1:0] ed_idx_r, ed_idx_nxt;

  logic                       item_req_r;
  logic [tld_pkg::KEY_W-1:0]  item_key_r;
  logic                       item_has_data_r;

  logic [tld_pkg::KEY_W-1:0]  mem [BUFFER_DEPTH];
  logic [tld_pkg::KEY_W-1:0]  mem_rdata_r;
  logic [SLOT_W-1:0]          mem_raddr;
  logic                       mem_we;
  logic [tld_pkg::KEY_W-1:0]  store_char;
  logic [IDX_W-1:0]           ed_after_store;
  logic [IDX_W-1:0]           ed_before;

  logic                       res_echo_valid_r, res_echo_valid_nxt;
  logic [tld_pkg::KEY_W-1:0]  res_echo_char_r, res_echo_char_nxt;
  logic [tld_pkg::ERASE_W-1:0] res_erase_r, res_erase_nxt;
  logic                       res_line_ready_r, res_line_ready_nxt;
  logic                       res_dump_r, res_dump_nxt;
  logic                       res_dropped_r, res_dropped_nxt;
  logic [tld_pkg::RSTAT_W-1:0] res_status_r, res_status_nxt;
  logic [tld_pkg::KEY_W-1:0]  res_rchar_r, res_rchar_nxt;
  logic                       res_rend_r, res_rend_nxt;

  logic out_valid_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_en_r  <= 1'b1;
      line_buf_r <= 1'b1;
      erase_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tld_pkg::CFG_ECHO_ENABLE:   echo_en_r  <= cfg_wdata[0];
        tld_pkg::CFG_LINE_BUFFERED: line_buf_r <= cfg_wdata[0];
        tld_pkg::CFG_ERASE_ENABLE:  erase_en_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign store_char     = (item_key_r == tld_pkg::KEY_CR) ? tld_pkg::KEY_LF : item_key_r;
  assign ed_after_store = idx_next(ed_idx_r);
  assign ed_before      = idx_prev(ed_idx_r);
  assign mem_we         = (cmd.op == tld_pkg::OP_STORE);
  assign mem_raddr      = (cmd.op == tld_pkg::OP_KILL_ISSUE) ?
                          ed_before[SLOT_W-1:0] : rd_idx_r[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ed_idx_r[SLOT_W-1:0]] <= store_char;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    rd_idx_nxt         = rd_idx_r;
    cm_idx_nxt         = cm_idx_r;
    ed_idx_nxt         = ed_idx_r;
    res_echo_valid_nxt = res_echo_valid_r;
    res_echo_char_nxt  = res_echo_char_r;
    res_erase_nxt      = res_erase_r;
    res_line_ready_nxt = res_line_ready_r;
    res_dump_nxt       = res_dump_r;
    res_dropped_nxt    = res_dropped_r;
    res_status_nxt     = res_status_r;
    res_rchar_nxt      = res_rchar_r;
    res_rend_nxt       = res_rend_r;
    unique case (cmd.op)
      tld_pkg::OP_CAPTURE: begin
        res_echo_valid_nxt = 1'b0;
        res_echo_char_nxt  = '0;
        res_erase_nxt      = '0;
        res_line_ready_nxt = 1'b0;
        res_dump_nxt       = 1'b0;
        res_dropped_nxt    = 1'b0;
        res_status_nxt     = tld_pkg::RS_CHAR;
        res_rchar_nxt      = '0;
        res_rend_nxt       = 1'b0;
      end
      tld_pkg::OP_DUMP: begin
        res_dump_nxt = 1'b1;
      end
      tld_pkg::OP_ERASE: begin
        if (ed_idx_r != cm_idx_r) begin
          ed_idx_nxt    = idx_prev(ed_idx_r);
          res_erase_nxt = ERASE_W_ONE;
        end
      end
      tld_pkg::OP_STORE: begin
        ed_idx_nxt = ed_after_store;
        if (echo_en_r) begin
          res_echo_valid_nxt = 1'b1;
          res_echo_char_nxt  = store_char;
        end
        if (!line_buf_r || store_char == tld_pkg::KEY_LF ||
            store_char == tld_pkg::KEY_CTRL_D || is_full(ed_after_store, rd_idx_r)) begin
          cm_idx_nxt         = ed_after_store;
          res_line_ready_nxt = 1'b1;
        end
      end
      tld_pkg::OP_DROP: begin
        res_dropped_nxt = 1'b1;
      end
      tld_pkg::OP_NOTHING: begin
        res_status_nxt = tld_pkg::RS_EMPTY;
      end
      tld_pkg::OP_RD_FINISH: begin
        if (mem_rdata_r == tld_pkg::KEY_CTRL_D) begin
          if (item_has_data_r) begin
            res_status_nxt = tld_pkg::RS_EOF_HLD;
          end else begin
            rd_idx_nxt     = idx_next(rd_idx_r);
            res_status_nxt = tld_pkg::RS_EOF;
          end
        end else begin
          rd_idx_nxt     = idx_next(rd_idx_r);
          res_status_nxt = tld_pkg::RS_CHAR;
          res_rchar_nxt  = mem_rdata_r;
          res_rend_nxt   = (mem_rdata_r == tld_pkg::KEY_LF);
        end
      end
      tld_pkg::OP_KILL_STEP: begin
        ed_idx_nxt = idx_prev(ed_idx_r);
        if (res_erase_r != tld_pkg::ERASE_MAX) begin
          res_erase_nxt = res_erase_r + ERASE_W_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      cm_idx_r <= '0;
      ed_idx_r <= '0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      cm_idx_r <= cm_idx_nxt;
      ed_idx_r <= ed_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tld_pkg::OP_CAPTURE) begin
      item_req_r      <= in_req_type;
      item_key_r      <= in_key_code;
      item_has_data_r <= in_read_has_data;
    end
    res_echo_valid_r <= res_echo_valid_nxt;
    res_echo_char_r  <= res_echo_char_nxt;
    res_erase_r      <= res_erase_nxt;
    res_line_ready_r <= res_line_ready_nxt;
    res_dump_r       <= res_dump_nxt;
    res_dropped_r    <= res_dropped_nxt;
    res_status_r     <= res_status_nxt;
    res_rchar_r      <= res_rchar_nxt;
    res_rend_r       <= res_rend_nxt;
  end

  // Output register; a new item may be taken while this beat waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == tld_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tld_pkg::OP_EMIT) begin
      out_echo_valid    <= res_echo_valid_r;
      out_echo_char     <= res_echo_char_r;
      out_erase_count   <= res_erase_r;
      out_line_ready    <= res_line_ready_r;
      out_dump_request  <= res_dump_r;
      out_key_dropped   <= res_dropped_r;
      out_read_status   <= res_status_r;
      out_read_char     <= res_rchar_r;
      out_read_line_end <= res_rend_r;
    end
  end

  assign out_valid = out_valid_r;

  assign st.is_read        = (item_req_r == tld_pkg::REQ_READ);
  assign st.is_dump        = (item_key_r == tld_pkg::KEY_CTRL_P);
  assign st.is_kill        = (item_key_r == tld_pkg::KEY_CTRL_U);
  assign st.is_erase       = erase_en_r && (item_key_r == tld_pkg::KEY_CTRL_H ||
                                            item_key_r == tld_pkg::KEY_DEL);
  assign st.can_store      = (item_key_r != tld_pkg::KEY_NUL) && !is_full(ed_idx_r, rd_idx_r);
  assign st.line_empty     = (ed_idx_r == cm_idx_r);
  assign st.none_committed = (rd_idx_r == cm_idx_r);
  assign st.mem_is_lf      = (mem_rdata_r == tld_pkg::KEY_LF);
  assign st.out_free       = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_read_within_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && rd_idx_r != $past(rd_idx_r)) |-> $past(rd_idx_r != cm_idx_r))
    else $error("read index moved past the commit index");

  a_commit_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cm_idx_r != $past(cm_idx_r)) |->
      $past(cmd.op == tld_pkg::OP_STORE))
    else $error("commit index moved without a stored key");

  a_edit_moves_on_edit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && ed_idx_r != $past(ed_idx_r)) |->
      $past(cmd.op == tld_pkg::OP_STORE || cmd.op == tld_pkg::OP_ERASE ||
            cmd.op == tld_pkg::OP_KILL_STEP))
    else $error("edit index moved without an edit command");

  a_store_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tld_pkg::OP_STORE) |-> !is_full(ed_idx_r, rd_idx_r))
    else $error("key stored into a full line store");
`endif

endmodule

[test/terminal_line_discipline_tb.sv]
// ----------------------------------------------------------------------------
// terminal_line_discipline_tb
// Self-checking bench for the console line editor. Key strokes and reader
// pulls are queued, driven in bursts with random gaps, and every accepted
// request is run through a behavioral copy of the ring store and its three
// indices. Result beats, taken under a random stall pattern, are compared
// field by field with the oldest predicted response. All eight combinations
// of echo, line buffering and erase handling are swept between phases.
// ----------------------------------------------------------------------------
module terminal_line_discipline_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = 128;
  localparam int IDX_W         = $clog2(2 * DEPTH);
  localparam int PHASE_ITEMS   = 250;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 30;

  typedef struct packed {
    logic                        req_type;
    logic [tld_pkg::KEY_W-1:0]   key_code;
    logic                        read_has_data;
  } tty_req_t;

  typedef struct packed {
    logic                        echo_valid;
    logic [tld_pkg::KEY_W-1:0]   echo_char;
    logic [tld_pkg::ERASE_W-1:0] erase_count;
    logic                        line_ready;
    logic                        dump_request;
    logic                        key_dropped;
    logic [tld_pkg::RSTAT_W-1:0] read_status;
    logic [tld_pkg::KEY_W-1:0]   read_char;
    logic                        read_line_end;
  } tty_res_t;

  // Each setting is {echo_enable, line_buffered, erase_enable}.
  localparam logic [2:0] MODE_SWEEP [8] = '{3'b000, 3'b101, 3'b010, 3'b110,
                                            3'b011, 3'b100, 3'b001, 3'b111};

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [tld_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tld_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tld_in_if  in_ch();
  tld_out_if out_ch();

  terminal_line_discipline #(
    .BUFFER_DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the editor state.
  logic [tld_pkg::KEY_W-1:0] line_mem [DEPTH];
  logic [IDX_W-1:0] rd_idx = '0;
  logic [IDX_W-1:0] cm_idx = '0;
  logic [IDX_W-1:0] ed_idx = '0;
  logic             echo_on = 1'b1;
  logic             buffered_on = 1'b1;
  logic             erase_on = 1'b1;

  tty_req_t queued_requests [$];
  tty_res_t awaited_results [$];
  int       queued_total;
  int       results_seen;
  int       mismatches;
  logic     in_beat_taken;
  int       burst_left = 1;
  int       gap_left;
  logic [15:0] stall_pat;
  logic [5:0]  pat_age;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tty_res_t tty_response(tty_req_t rq);
    tty_res_t                  r;
    logic [tld_pkg::KEY_W-1:0] c;
    logic [IDX_W-1:0]          prev_idx;
    logic [IDX_W-1:0]          fill;
    r = '0;
    if (rq.req_type == tld_pkg::REQ_KEY) begin
      fill = ed_idx - rd_idx;
      if (rq.key_code == tld_pkg::KEY_CTRL_P) begin
        r.dump_request = 1'b1;
      end else if (rq.key_code == tld_pkg::KEY_CTRL_U) begin
        // Walk back over the uncommitted text, stopping after a newline.
        prev_idx = ed_idx - IDX_W'(1);
        while (ed_idx != cm_idx && line_mem[prev_idx[IDX_W-2:0]] != tld_pkg::KEY_LF) begin
          ed_idx = prev_idx;
          if (r.erase_count != tld_pkg::ERASE_MAX) r.erase_count++;
          prev_idx = ed_idx - IDX_W'(1);
        end
      end else if ((rq.key_code == tld_pkg::KEY_CTRL_H || rq.key_code == tld_pkg::KEY_DEL)
                   && erase_on) begin
        if (ed_idx != cm_idx) begin
          ed_idx = ed_idx - IDX_W'(1);
          r.erase_count = tld_pkg::ERASE_W'(1);
        end
      end else if (rq.key_code != tld_pkg::KEY_NUL && fill < DEPTH) begin
        c = (rq.key_code == tld_pkg::KEY_CR) ? tld_pkg::KEY_LF : rq.key_code;
        line_mem[ed_idx[IDX_W-2:0]] = c;
        ed_idx = ed_idx + IDX_W'(1);
        fill = ed_idx - rd_idx;
        if (echo_on) begin
          r.echo_valid = 1'b1;
          r.echo_char = c;
        end
        if (!buffered_on || c == tld_pkg::KEY_LF || c == tld_pkg::KEY_CTRL_D ||
            fill == DEPTH) begin
          cm_idx = ed_idx;
          r.line_ready = 1'b1;
        end
      end else begin
        r.key_dropped = 1'b1;
      end
    end else if (rd_idx == cm_idx) begin
      r.read_status = tld_pkg::RS_EMPTY;
    end else begin
      c = line_mem[rd_idx[IDX_W-2:0]];
      if (c == tld_pkg::KEY_CTRL_D) begin
        if (rq.read_has_data) begin
          r.read_status = tld_pkg::RS_EOF_HLD;
        end else begin
          rd_idx = rd_idx + IDX_W'(1);
          r.read_status = tld_pkg::RS_EOF;
        end
      end else begin
        rd_idx = rd_idx + IDX_W'(1);
        r.read_status = tld_pkg::RS_CHAR;
        r.read_char = c;
        r.read_line_end = (c == tld_pkg::KEY_LF);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("[%0t] beat %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic push_key(logic [tld_pkg::KEY_W-1:0] k);
    queued_requests.push_back(tty_req_t'({tld_pkg::REQ_KEY, k, 1'($urandom)}));
    queued_total++;
  endtask

  task automatic push_read(logic has_data);
    queued_requests.push_back(tty_req_t'({tld_pkg::REQ_READ, 8'($urandom), has_data}));
    queued_total++;
  endtask

  task automatic write_reg(logic [tld_pkg::CFG_IDX_W-1:0] idx, logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tld_pkg::CFG_ECHO_ENABLE: echo_on = val;
      tld_pkg::CFG_LINE_BUFFERED: buffered_on = val;
      default: erase_on = val;
    endcase
  endtask

  task automatic wait_idle();
    while (queued_requests.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly typed lines with edits and a terminator, followed by reads that
  // drain part of the store; the rest is reader bursts and raw noise.
  task automatic queue_random_phase(int n);
    int stop;
    int len;
    int pick;
    stop = queued_total + n;
    while (queued_total < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 24);
        repeat (len) begin
          pick = $urandom_range(0, 39);
          if (pick < 3) push_key((pick == 0) ? tld_pkg::KEY_CTRL_H : tld_pkg::KEY_DEL);
          else if (pick == 3) push_key(tld_pkg::KEY_CTRL_U);
          else if (pick == 4) push_key(8'($urandom));
          else if (pick == 5) push_key(tld_pkg::KEY_CTRL_P);
          else push_key(8'($urandom_range(8'h20, 8'h7E)));
        end
        case ($urandom_range(0, 3))
          0: push_key(tld_pkg::KEY_CR);
          1: push_key(tld_pkg::KEY_CTRL_D);
          default: push_key(tld_pkg::KEY_LF);
        endcase
        repeat ($urandom_range(len / 2, len + 3)) push_read($urandom_range(0, 3) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 10)) push_read($urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          queued_requests.push_back(tty_req_t'({1'($urandom), 8'($urandom), 1'($urandom)}));
          queued_total++;
        end
      end
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin : request_driver
    tty_req_t rq;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (queued_requests.size() > 0) begin
        rq = queued_requests.pop_front();
        in_ch.req_type <= rq.req_type;
        in_ch.key_code <= rq.key_code;
        in_ch.read_has_data <= rq.read_has_data;
        in_ch.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: ready follows a rotating pattern, reloaded each time the 6-bit age counter wraps.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      pat_age++;
      out_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  always @(posedge clk) begin
    in_beat_taken <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      awaited_results.push_back(tty_response(
        {in_ch.req_type, in_ch.key_code, in_ch.read_has_data}));
    end
  end

  always @(posedge clk) begin : result_compare
    tty_res_t got;
    tty_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.echo_valid, out_ch.echo_char, out_ch.erase_count, out_ch.line_ready,
             out_ch.dump_request, out_ch.key_dropped, out_ch.read_status, out_ch.read_char,
             out_ch.read_line_end};
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing pending", got));
      end else begin
        want = awaited_results.pop_front();
        check_field("echo_valid", 8'(got.echo_valid), 8'(want.echo_valid));
        check_field("echo_char", got.echo_char, want.echo_char);
        check_field("erase_count", got.erase_count, want.erase_count);
        check_field("line_ready", 8'(got.line_ready), 8'(want.line_ready));
        check_field("dump_request", 8'(got.dump_request), 8'(want.dump_request));
        check_field("key_dropped", 8'(got.key_dropped), 8'(want.key_dropped));
        check_field("read_status", 8'(got.read_status), 8'(want.read_status));
        check_field("read_char", got.read_char, want.read_char);
        check_field("read_line_end", 8'(got.read_line_end), 8'(want.read_line_end));
      end
      results_seen++;
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = tld_pkg::REQ_KEY;
    in_ch.key_code = '0;
    in_ch.read_has_data = 1'b0;
    out_ch.ready = 1'b0;
    pat_age = '0;
    stall_pat = '1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed checks under the reset settings.
    push_read(1'b0);                       // nothing committed yet
    push_key(tld_pkg::KEY_NUL);            // null key is dropped
    push_key(tld_pkg::KEY_CTRL_H);         // erase on an empty line
    push_key(tld_pkg::KEY_DEL);
    push_key(tld_pkg::KEY_CTRL_U);         // kill on an empty line
    push_key(tld_pkg::KEY_CTRL_P);
    push_key(8'h61);
    push_key(8'hFF);
    push_key(tld_pkg::KEY_CTRL_H);
    push_key(8'h80);
    push_key(tld_pkg::KEY_DEL);
    push_key(8'h01);
    push_key(tld_pkg::KEY_CR);             // stored as newline, commits
    push_key(8'h78);
    push_key(8'h79);
    push_key(tld_pkg::KEY_CTRL_U);         // kills the two open characters
    push_key(tld_pkg::KEY_CTRL_D);
    push_read(1'b1);
    push_read(1'b0);
    push_read(1'b1);                       // newline ends the line
    push_read(1'b1);                       // end of file held back
    push_read(1'b0);                       // end of file consumed
    push_read(1'b1);
    wait_idle();

    foreach (MODE_SWEEP[i]) begin
      write_reg(tld_pkg::CFG_ECHO_ENABLE, MODE_SWEEP[i][2]);
      write_reg(tld_pkg::CFG_LINE_BUFFERED, MODE_SWEEP[i][1]);
      write_reg(tld_pkg::CFG_ERASE_ENABLE, MODE_SWEEP[i][0]);
      @(negedge clk);
      cfg_we <= 1'b0;
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
